### hdl/xpbd_distance_constraint_assert.svh
// Assertion macros for the distance-constraint projector checker.
// Each macro samples on clk_i and holds off while rst_ni is low.
`ifndef XPBD_DISTANCE_CONSTRAINT_ASSERT_SVH
`define XPBD_DISTANCE_CONSTRAINT_ASSERT_SVH

// Clocked assertion with a fixed message.
`define XDC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("xdc assertion failed");

// Clocked assertion with a caller message.
`define XDC_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

### hdl/xdc_pkg.sv
// Shared types and constants for the distance-constraint projector.
// No dependencies; imported by the top level, the checker and the testbench.
package xdc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  localparam int unsigned IdxW     = 10;
  localparam int unsigned WordW    = 32;
  localparam int unsigned InDataW  = 184;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned VtxW     = 4 * WordW;

  // x in the lowest bits, inverse mass in the highest
  typedef struct packed {
    logic [WordW-1:0] w;
    logic [WordW-1:0] z;
    logic [WordW-1:0] y;
    logic [WordW-1:0] x;
  } vertex_t;

endpackage

### hdl/xdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module xdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/xpbd_distance_constraint.sv
// XPBD distance-constraint projector: vertex store plus bit-serial solver.
// Depends on xdc_pkg and xdc_ram.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tuser opcode, tdata vertex/edge fields
//   m_axis    out  tvalid/tready          tdata stored vertex of a read
//   cfg       in   cfg_we_i               cfg_wdata_i compliance alpha
//
// One item at a time. Every item first reduces its 10-bit indexes, one bit a cycle.
// A read may also wait on the output register.
// A solve runs a 33-step square root and a 49-step divider.
// Reset clears control state only; the vertex store is undefined until written.
// A finished read result waits in the output register while new beats are taken.
module xpbd_distance_constraint import xdc_pkg::*; #(
  parameter int unsigned VERTEX_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // lsb up: vertex_a[10], vertex_b[10], rest_length[32], data_x[32], data_y[32],
  //         data_z[32], inverse_mass[32], zero pad[4]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode[2]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // lsb up: read_x[32], read_y[32], read_z[32], read_inverse_mass[32]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [WordW-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = $clog2(VERTEX_COUNT);
  localparam int unsigned RW = AW + 1;
  localparam logic [RW-1:0] VcR = RW'(VERTEX_COUNT);

  localparam logic [5:0] ModLast  = 6'(IdxW - 1);
  localparam logic [5:0] SqrLast  = 6'd32;
  localparam logic [5:0] RootLast = 6'd32;
  localparam logic [5:0] DivLast  = 6'd48;
  localparam logic [5:0] MwLast   = 6'd31;
  localparam logic [5:0] MuLast   = 6'd16;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_MODI = 18'h00002,
    ST_WMEM = 18'h00004,
    ST_RDA  = 18'h00008,
    ST_RDB  = 18'h00010,
    ST_LDB  = 18'h00020,
    ST_SQR  = 18'h00040,
    ST_SUM  = 18'h00080,
    ST_SQRT = 18'h00100,
    ST_LCHK = 18'h00200,
    ST_DIV  = 18'h00400,
    ST_MSET = 18'h00800,
    ST_MULW = 18'h01000,
    ST_USET = 18'h02000,
    ST_MULU = 18'h04000,
    ST_WRA  = 18'h08000,
    ST_WRB  = 18'h10000,
    ST_ROUT = 18'h20000
  } state_e;

  function automatic logic [WordW-1:0] sat_add(logic [WordW-1:0] p, logic neg,
                                               logic [48:0] corr);
    logic signed [50:0] v;
    logic signed [50:0] c;
    c = signed'({2'b00, corr});
    v = signed'({{19{p[31]}}, p});
    v = neg ? v - c : v + c;
    if (v > 51'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -51'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic ovld_q, ovld_d;
  logic [WordW-1:0] alpha_q;

  opcode_e op_q;
  logic [IdxW-1:0] ia_q, ib_q;
  logic [AW-1:0] ra_q, rb_q;
  logic [WordW-1:0] rest_q;
  vertex_t wdat_q, pa_q, pb_q;
  logic [32:0] w_q;
  logic [2:0] dneg_q;
  logic [32:0] dmag_q [3];
  logic [65:0] sq_q [3];
  logic [65:0] rad_q;
  logic [32:0] root_q;
  logic [33:0] rem_q;
  logic sneg_q;
  logic [48:0] dnum_q [4];
  logic [33:0] drem_q [4];
  logic [33:0] dden_q;
  logic [80:0] mw_q [2];
  logic [47:0] m_q [2];
  logic [64:0] mu_q [6];
  logic [OutDataW-1:0] out_q;

  // memory port
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  vertex_t mem_wdata, mem_rdata;

  xdc_ram #(.WIDTH(VtxW), .DEPTH(VERTEX_COUNT)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // step values of the serial units
  logic [RW-1:0] ta, tb;
  logic [AW-1:0] ra_nx, rb_nx;
  logic [32:0] d_sub [3];
  logic [32:0] pa_c [3], pb_c [3];
  logic [33:0] sq_sum [3];
  logic [35:0] rt_rem, rt_trial;
  logic [34:0] dv_r2 [4];
  logic [33:0] dv_den [4];
  logic dv_ge [4];
  logic [49:0] mw_sum [2];
  logic [48:0] mu_sum [6];
  logic [34:0] negc;
  logic [32:0] magc;
  vertex_t new_a, new_b;

  always_comb begin
    ta = {ra_q, ia_q[IdxW-1]};
    tb = {rb_q, ib_q[IdxW-1]};
    ra_nx = (ta >= VcR) ? AW'(ta - VcR) : ta[AW-1:0];
    rb_nx = (tb >= VcR) ? AW'(tb - VcR) : tb[AW-1:0];
    pa_c[0] = {pa_q.x[31], pa_q.x};
    pa_c[1] = {pa_q.y[31], pa_q.y};
    pa_c[2] = {pa_q.z[31], pa_q.z};
    pb_c[0] = {mem_rdata.x[31], mem_rdata.x};
    pb_c[1] = {mem_rdata.y[31], mem_rdata.y};
    pb_c[2] = {mem_rdata.z[31], mem_rdata.z};
    for (int i = 0; i < 3; i++) begin
      d_sub[i] = pa_c[i] - pb_c[i];
      sq_sum[i] = {1'b0, sq_q[i][65:33]} + (sq_q[i][0] ? {1'b0, dmag_q[i]} : 34'd0);
    end
    rt_rem = {rem_q, rad_q[65:64]};
    rt_trial = {1'b0, root_q, 2'b01};
    for (int k = 0; k < 4; k++) begin
      dv_den[k] = (k == 0) ? dden_q : {1'b0, root_q};
      dv_r2[k] = {drem_q[k], dnum_q[k][48]};
      dv_ge[k] = dv_r2[k] >= {1'b0, dv_den[k]};
    end
    for (int v = 0; v < 2; v++) begin
      mw_sum[v] = {1'b0, mw_q[v][80:32]} + (mw_q[v][0] ? {1'b0, dnum_q[0]} : 50'd0);
    end
    for (int j = 0; j < 6; j++) begin
      mu_sum[j] = {1'b0, mu_q[j][64:17]} + (mu_q[j][0] ? {1'b0, m_q[j / 3]} : 49'd0);
    end
    negc = {3'b000, rest_q} - {2'b00, root_q};
    magc = negc[34] ? 33'(-negc) : negc[32:0];
    new_a.w = pa_q.w;
    new_a.x = sat_add(pa_q.x, sneg_q ^ dneg_q[0], mu_q[0][64:16]);
    new_a.y = sat_add(pa_q.y, sneg_q ^ dneg_q[1], mu_q[1][64:16]);
    new_a.z = sat_add(pa_q.z, sneg_q ^ dneg_q[2], mu_q[2][64:16]);
    new_b.w = pb_q.w;
    new_b.x = sat_add(pb_q.x, ~(sneg_q ^ dneg_q[0]), mu_q[3][64:16]);
    new_b.y = sat_add(pb_q.y, ~(sneg_q ^ dneg_q[1]), mu_q[4][64:16]);
    new_b.z = sat_add(pb_q.z, ~(sneg_q ^ dneg_q[2]), mu_q[5][64:16]);
  end

  always_comb begin
    mem_we = (state_q == ST_WMEM) || (state_q == ST_WRA) || (state_q == ST_WRB);
    mem_waddr = (state_q == ST_WRB) ? rb_q : ra_q;
    case (state_q)
      ST_WRA:  mem_wdata = new_a;
      ST_WRB:  mem_wdata = new_b;
      default: mem_wdata = wdat_q;
    endcase
    mem_re = (state_q == ST_RDA) || (state_q == ST_RDB);
    mem_raddr = (state_q == ST_RDB) ? rb_q : ra_q;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q + 6'd1;
    ovld_d = ovld_q & ~m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (s_axis_tvalid) begin
          state_d = ST_MODI;
        end
      end
      ST_MODI: begin
        if (cnt_q == ModLast) begin
          case (op_q)
            OP_WRITE: state_d = ST_WMEM;
            OP_SOLVE: state_d = ST_RDA;
            OP_READ:  state_d = ST_RDA;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_WMEM: state_d = ST_IDLE;
      ST_RDA:  state_d = (op_q == OP_READ) ? ST_ROUT : ST_RDB;
      ST_RDB:  state_d = ST_LDB;
      ST_LDB: begin
        cnt_d = '0;
        // nothing moves when both vertices are pinned
        state_d = (({1'b0, pa_q.w} + {1'b0, mem_rdata.w}) == 33'd0) ? ST_IDLE : ST_SQR;
      end
      ST_SQR:  if (cnt_q == SqrLast) state_d = ST_SUM;
      ST_SUM: begin
        cnt_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: if (cnt_q == RootLast) state_d = ST_LCHK;
      ST_LCHK: begin
        cnt_d = '0;
        state_d = (root_q == '0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV:  if (cnt_q == DivLast) state_d = ST_MSET;
      ST_MSET: begin
        cnt_d = '0;
        state_d = ST_MULW;
      end
      ST_MULW: if (cnt_q == MwLast) state_d = ST_USET;
      ST_USET: begin
        cnt_d = '0;
        state_d = ST_MULU;
      end
      ST_MULU: if (cnt_q == MuLast) state_d = ST_WRA;
      ST_WRA:  state_d = ST_WRB;
      ST_WRB:  state_d = ST_IDLE;
      ST_ROUT: begin
        // hold until the output register is free
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      alpha_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q   <= opcode_e'(s_axis_tuser);
        ia_q   <= s_axis_tdata[9:0];
        ib_q   <= s_axis_tdata[19:10];
        rest_q <= s_axis_tdata[51:20];
        wdat_q <= s_axis_tdata[179:52];
        ra_q   <= '0;
        rb_q   <= '0;
      end
      ST_MODI: begin
        ra_q <= ra_nx;
        rb_q <= rb_nx;
        ia_q <= {ia_q[IdxW-2:0], 1'b0};
        ib_q <= {ib_q[IdxW-2:0], 1'b0};
      end
      ST_RDB: pa_q <= mem_rdata;
      ST_LDB: begin
        pb_q <= mem_rdata;
        w_q  <= {1'b0, pa_q.w} + {1'b0, mem_rdata.w};
        for (int i = 0; i < 3; i++) begin
          dneg_q[i] <= d_sub[i][32];
          dmag_q[i] <= d_sub[i][32] ? 33'(-d_sub[i]) : d_sub[i];
          sq_q[i]   <= {33'd0, (d_sub[i][32] ? 33'(-d_sub[i]) : d_sub[i])};
        end
      end
      ST_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= {sq_sum[i], sq_q[i][32:1]};
        end
      end
      ST_SUM: begin
        rad_q  <= sq_q[0] + sq_q[1] + sq_q[2];
        root_q <= '0;
        rem_q  <= '0;
      end
      ST_SQRT: begin
        rad_q <= {rad_q[63:0], 2'b00};
        if (rt_rem >= rt_trial) begin
          rem_q  <= 34'(rt_rem - rt_trial);
          root_q <= {root_q[31:0], 1'b1};
        end else begin
          rem_q  <= rt_rem[33:0];
          root_q <= {root_q[31:0], 1'b0};
        end
      end
      ST_LCHK: begin
        sneg_q    <= negc[34];
        dnum_q[0] <= {magc, 16'd0};
        for (int i = 0; i < 3; i++) begin
          dnum_q[i+1] <= {dmag_q[i], 16'd0};
        end
        for (int k = 0; k < 4; k++) begin
          drem_q[k] <= '0;
        end
        dden_q <= {2'b00, alpha_q} + {1'b0, w_q};
      end
      ST_DIV: begin
        for (int k = 0; k < 4; k++) begin
          drem_q[k] <= dv_ge[k] ? 34'(dv_r2[k] - {1'b0, dv_den[k]}) : dv_r2[k][33:0];
          dnum_q[k] <= {dnum_q[k][47:0], dv_ge[k]};
        end
      end
      ST_MSET: begin
        mw_q[0] <= {49'd0, pa_q.w};
        mw_q[1] <= {49'd0, pb_q.w};
      end
      ST_MULW: begin
        for (int v = 0; v < 2; v++) begin
          mw_q[v] <= {mw_sum[v], mw_q[v][31:1]};
        end
      end
      ST_USET: begin
        for (int v = 0; v < 2; v++) begin
          // cap the mass-weighted step at 48 bits
          m_q[v] <= (|mw_q[v][80:64]) ? {48{1'b1}} : mw_q[v][63:16];
          for (int i = 0; i < 3; i++) begin
            mu_q[v*3+i] <= {48'd0, dnum_q[i+1][16:0]};
          end
        end
      end
      ST_MULU: begin
        for (int j = 0; j < 6; j++) begin
          mu_q[j] <= {mu_sum[j], mu_q[j][16:1]};
        end
      end
      ST_ROUT: begin
        if (!ovld_q || m_axis_tready) begin
          out_q <= mem_rdata;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/xdc_checker.sv
// Port-level checker for the distance-constraint projector, bound to the top.
// Depends on xdc_pkg and xpbd_distance_constraint_assert.svh.
`include "xpbd_distance_constraint_assert.svh"

module xdc_checker import xdc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  `XDC_ASSERT_MSG(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "out beat changed while stalled")
  `XDC_ASSERT_MSG(a_busy_after_beat, in_beat |=> !s_axis_tready ##1 !s_axis_tready, "ready too soon after beat")
  `XDC_ASSERT(a_result_from_busy, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

endmodule

bind xpbd_distance_constraint xdc_checker u_xdc_checker (.*);

### tb/sv/tb_xpbd_distance_constraint.sv
// Self-checking bench for the XPBD distance-constraint projector.
// Depends on xdc_pkg and the xpbd_distance_constraint RTL; predicts each read beat.
module tb_xpbd_distance_constraint import xdc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class vertex_scoreboard;
    logic [31:0] pos_x [1024];
    logic [31:0] pos_y [1024];
    logic [31:0] pos_z [1024];
    logic [31:0] inv_mass [1024];
    logic [31:0] alpha;
    vertex_t     read_q[$];
    int          mismatches;

    function new();
      alpha = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] add_sat(logic [31:0] p, bit neg, longint unsigned corr);
      longint v;
      v = longint'(signed'(p));
      v = neg ? v - longint'(corr) : v + longint'(corr);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void project_edge(int a, int b, logic [31:0] rest);
      longint unsigned wa, wb, w, ad[3], len, smag, m, umag, corr;
      longint d[3];
      logic [127:0] sumsq, cand, prod;
      longint negc;
      bit sneg, neg;
      int idx;
      wa = inv_mass[a];
      wb = inv_mass[b];
      w = wa + wb;
      if (w == 0) return;
      d[0] = longint'(signed'(pos_x[a])) - longint'(signed'(pos_x[b]));
      d[1] = longint'(signed'(pos_y[a])) - longint'(signed'(pos_y[b]));
      d[2] = longint'(signed'(pos_z[a])) - longint'(signed'(pos_z[b]));
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        ad[i] = d[i] < 0 ? -d[i] : d[i];
        sumsq += 128'(ad[i]) * 128'(ad[i]);
      end
      len = 0;
      for (int bt = 33; bt >= 0; bt--) begin
        cand = 128'(len | (64'd1 << bt));
        if (cand * cand <= sumsq) len = cand[63:0];
      end
      if (len == 0) return;
      negc = longint'(rest) - longint'(len);
      sneg = negc < 0;
      smag = ((negc < 0 ? -negc : negc) << 16) / (w + longint'(alpha));
      for (int v = 0; v < 2; v++) begin
        idx = v ? b : a;
        prod = (128'(smag) * 128'(v ? wb : wa)) >> 16;
        m = (prod > 128'h0000_FFFF_FFFF_FFFF) ? 64'h0000_FFFF_FFFF_FFFF : prod[63:0];
        for (int i = 0; i < 3; i++) begin
          umag = (ad[i] << 16) / len;
          prod = (128'(m) * 128'(umag)) >> 16;
          corr = prod[63:0];
          neg = sneg ^ (d[i] < 0) ^ (v == 1);
          case (i)
            0: pos_x[idx] = add_sat(pos_x[idx], neg, corr);
            1: pos_y[idx] = add_sat(pos_y[idx], neg, corr);
            default: pos_z[idx] = add_sat(pos_z[idx], neg, corr);
          endcase
        end
      end
    endfunction

    function void note_item(opcode_e op, int a, int b, logic [31:0] rest, logic [31:0] x,
                            logic [31:0] y, logic [31:0] z, logic [31:0] im);
      vertex_t vx;
      case (op)
        OP_WRITE: begin
          pos_x[a] = x; pos_y[a] = y; pos_z[a] = z; inv_mass[a] = im;
        end
        OP_SOLVE: project_edge(a, b, rest);
        OP_READ: begin
          vx.x = pos_x[a]; vx.y = pos_y[a]; vx.z = pos_z[a]; vx.w = inv_mass[a];
          read_q.push_back(vx);
        end
        default: ;
      endcase
    endfunction

    function void check_read(vertex_t got);
      vertex_t exp_v;
      if (read_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected read beat %h", got);
        return;
      end
      exp_v = read_q.pop_front();
      if (got !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("read mismatch: exp x=%h y=%h z=%h w=%h got x=%h y=%h z=%h w=%h",
                   exp_v.x, exp_v.y, exp_v.z, exp_v.w, got.x, got.y, got.z, got.w);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [WordW-1:0]    cfg_wdata_i = '0;

  vertex_scoreboard vertex_sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  bit  written [1024];
  int  written_list[$];

  xpbd_distance_constraint #(.VERTEX_COUNT(1024)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  always #10 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) vertex_sb.check_read(m_axis_tdata);
  end

  task automatic send_beat(opcode_e op, int a, int b, logic [31:0] rest, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [31:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, im, z, y, x, rest, b[9:0], a[9:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    vertex_sb.note_item(op, a, b, rest, x, y, z, im);
    if (op == OP_WRITE && !written[a]) begin
      written[a] = 1;
      written_list.push_back(a);
    end
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_reads();
    while (vertex_sb.read_q.size() > 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_alpha(logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vertex_sb.alpha = val;
  endtask

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  task automatic random_beat();
    int r;
    logic [31:0] im;
    r = $urandom_range(99);
    im = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4 << 16);
    if (r < 30 || written_list.size() < 2)
      send_beat(OP_WRITE, ($urandom_range(1) ? $urandom_range(1023) : $urandom_range(15)),
                $urandom_range(1023), $urandom, pick_coord(), pick_coord(), pick_coord(),
                ($urandom_range(9) == 0) ? 32'd0 : im);
    else if (r < 75)
      send_beat(OP_SOLVE, pick_written(), pick_written(),
                ($urandom_range(2) == 0) ? $urandom : $urandom_range(0, 8 << 16),
                $urandom, $urandom, $urandom, $urandom);
    else if (r < 95)
      send_beat(OP_READ, pick_written(), $urandom_range(1023), $urandom,
                $urandom, $urandom, $urandom, $urandom);
    else
      send_beat(OP_NOP, $urandom_range(1023), $urandom_range(1023), $urandom,
                $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #(20ms);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_alpha(32'd0);

    // directed: extremes, pinned pair, coincident vertex, unused opcode
    send_beat(OP_WRITE, 0, 1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    send_beat(OP_WRITE, 1023, 0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    send_beat(OP_WRITE, 1, 0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_beat(OP_WRITE, 2, 0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
    send_beat(OP_WRITE, 3, 0, 32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0001_0000);
    send_beat(OP_WRITE, 4, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_beat(OP_SOLVE, 1, 2, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_SOLVE, 3, 3, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_SOLVE, 3, 4, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_SOLVE, 4, 3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_SOLVE, 0, 1023, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_SOLVE, 1, 4, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_NOP, 5, 6, 32'hFFFF_FFFF, '1, '1, '1, '1);
    for (int i = 0; i < 5; i++)
      send_beat(OP_READ, i, 1023 - i, '0, '0, '0, '0, '0);
    send_beat(OP_READ, 1023, 0, '0, '0, '0, '0, '0);
    go_quiet();
    drain_reads();

    // random phases across idle patterns and compliance settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_alpha(32'hFFFF_FFFF); end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  write_alpha($urandom); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; write_alpha(32'h0001_0000); end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; write_alpha(32'd0); end
      endcase
      for (int n = 0; n < 105; n++) random_beat();
      if (ph == 2) begin
        hold_req = 1;
        for (int n = 0; n < 12; n++)
          send_beat(OP_READ, pick_written(), 0, '0, '0, '0, '0, '0);
      end
      go_quiet();
      drain_reads();
    end

    if (vertex_sb.mismatches == 0 && vertex_sb.read_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/xdc_pkg.sv
hdl/xdc_ram.sv
hdl/xpbd_distance_constraint.sv
hdl/xdc_checker.sv
tb/sv/tb_xpbd_distance_constraint.sv
